### hw/rtl/learned_piecewise_linear_activation_top_defines.svh
// Assertion macros for the piecewise-linear activation block
`ifndef LEARNED_PIECEWISE_LINEAR_ACTIVATION_TOP_DEFINES_SVH
`define LEARNED_PIECEWISE_LINEAR_ACTIVATION_TOP_DEFINES_SVH

// same-cycle implication
`define LPLA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPLA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lpla_pkg.sv
// Shared constants and helpers for the piecewise-linear activation block
package lpla_pkg;

  localparam int SEGMENTS_DEF = 16;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FIN  = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_INV   = 1'b1;

  localparam logic [30:0] SCALE_RST = 31'd65536;

  // clip a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh7FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/lpla_ram.sv
// Generic RAM: one write port, two registered read ports
module lpla_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] wa_i,
  input  logic [W-1:0]         wd_i,
  input  logic                 re_a_i,
  input  logic [$clog2(D)-1:0] ra_a_i,
  output logic [W-1:0]         rd_a_o,
  input  logic                 re_b_i,
  input  logic [$clog2(D)-1:0] ra_b_i,
  output logic [W-1:0]         rd_b_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (re_a_i) begin
      rd_a_o <= mem_q[ra_a_i];
    end
    if (re_b_i) begin
      rd_b_o <= mem_q[ra_b_i];
    end
  end

endmodule

### hw/rtl/lpla_sweep.sv
// Finalize sequencer: rebuilds the offset table from the slope table
module lpla_sweep #(
  parameter int SEGMENTS = lpla_pkg::SEGMENTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [31:0]                 slope_rd_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic                        rd_en_o,
  output logic [$clog2(SEGMENTS)-1:0] rd_addr_o,
  output logic                        wr_en_o,
  output logic [$clog2(SEGMENTS)-1:0] wr_addr_o,
  output logic [31:0]                 wr_data_o
);

  localparam int AW   = $clog2(SEGMENTS);
  localparam int K    = SEGMENTS / 2;
  localparam int ACCW = 32 + AW + 1;
  localparam logic [AW-1:0] K_IDX    = AW'(K);
  localparam logic [AW-1:0] KL_IDX   = AW'(K - 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(SEGMENTS - 1);
  localparam logic [AW-1:0] ONE_IDX  = AW'(1);
  localparam logic HAS_LEFT = (K >= 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RIGHT = 3'd1;
  localparam logic [2:0] ST_LEFT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  logic [2:0]             st_q, st_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   rdv_q, rdleft_q, rdfirst_q;
  logic [AW-1:0]          rdaddr_q;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic [31:0]            last_q, last_d;
  logic signed [ACCW-1:0] base, sum;
  logic                   first_issue;

  assign rd_en_o   = (st_q == ST_RIGHT) || (st_q == ST_LEFT);
  assign rd_addr_o = idx_q;
  assign busy_o    = (st_q != ST_IDLE);
  assign done_o    = (st_q == ST_ZERO);
  assign first_issue = ((st_q == ST_RIGHT) && (idx_q == K_IDX)) ||
                       ((st_q == ST_LEFT) && (idx_q == KL_IDX));

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          st_d  = ST_RIGHT;
          idx_d = K_IDX;
        end
      end
      ST_RIGHT: begin
        if (idx_q == LAST_IDX) begin
          if (HAS_LEFT) begin
            st_d  = ST_LEFT;
            idx_d = KL_IDX;
          end else begin
            st_d = ST_DRAIN;
          end
        end else begin
          idx_d = idx_q + ONE_IDX;
        end
      end
      ST_LEFT: begin
        if (idx_q == ONE_IDX) begin
          st_d = ST_DRAIN;
        end else begin
          idx_d = idx_q - ONE_IDX;
        end
      end
      ST_DRAIN: st_d = ST_ZERO;
      ST_ZERO:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    base      = rdfirst_q ? '0 : acc_q;
    sum       = base - ACCW'($signed(slope_rd_i));
    acc_d     = acc_q;
    last_d    = start_i && (st_q == ST_IDLE) ? 32'd0 : last_q;
    wr_en_o   = 1'b0;
    wr_addr_o = rdaddr_q;
    wr_data_o = lpla_pkg::sat32(66'(base));
    if (rdv_q) begin
      wr_en_o = 1'b1;
      if (rdleft_q) begin
        wr_data_o = lpla_pkg::sat32(66'(sum));
        acc_d     = sum;
        last_d    = lpla_pkg::sat32(66'(sum));
      end else begin
        acc_d = base + ACCW'($signed(slope_rd_i));
      end
    end else if (st_q == ST_ZERO) begin
      // lowest segment copies its neighbor
      wr_en_o   = 1'b1;
      wr_addr_o = '0;
      wr_data_o = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      idx_q     <= '0;
      rdv_q     <= 1'b0;
      rdleft_q  <= 1'b0;
      rdfirst_q <= 1'b0;
      rdaddr_q  <= '0;
      acc_q     <= '0;
      last_q    <= '0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      rdv_q     <= rd_en_o;
      rdleft_q  <= (st_q == ST_LEFT);
      rdfirst_q <= first_issue;
      rdaddr_q  <= idx_q;
      acc_q     <= acc_d;
      last_q    <= last_d;
    end
  end

endmodule

### hw/rtl/learned_piecewise_linear_activation_top.sv
// Top level of the learned piecewise-linear activation block
// Usage:
//   Slave stream carries ops: tuser holds the op, tdata the slope index and
//   operand. Load writes one slope, finalize rebuilds the offset table,
//   evaluate produces one result beat on the master stream.
//   APB port: scale at 0x0, inverse_scale at 0x4, writes only while idle.
// Pipeline: an evaluate beat passes through stages A to F and the output register.
// Throughput: one beat per cycle through a seven-register pipeline while the
//   master side accepts results and no finalize sweep is pending.
// Finalize: after a finalize beat the slave side holds tready low until the
//   sweep over the slope memory ends; the sweep reads one slope and writes one
//   offset per cycle.
// Reset clears valid bits, the sweep sequencer and the scale registers to
//   1.0; slope and offset memories hold garbage until loaded and finalized.
// Stall: when the master side holds tready low with a result waiting, the
//   whole pipeline holds; nothing is dropped or repeated.
module learned_piecewise_linear_activation_top #(
  parameter int SEGMENTS = lpla_pkg::SEGMENTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] slope_index, [39:8] operand_value
  input  logic [39:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] activation, [39:32] segment_used
  output logic [39:0] m_axis_tdata,
  // [0] saturated
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "learned_piecewise_linear_activation_top_defines.svh"

  localparam int AW = $clog2(SEGMENTS);
  localparam int K  = SEGMENTS / 2;
  localparam logic [AW-1:0] LAST_IDX = AW'(SEGMENTS - 1);

  // configuration
  logic [30:0] scale_q, inv_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= lpla_pkg::SCALE_RST;
      inv_q   <= lpla_pkg::SCALE_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        lpla_pkg::REG_SCALE: scale_q <= pwdata[30:0];
        lpla_pkg::REG_INV:   inv_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lpla_pkg::REG_SCALE: prdata = {1'b0, scale_q};
      lpla_pkg::REG_INV:   prdata = {1'b0, inv_q};
      default:             prdata = '0;
    endcase
  end

  // pipeline control
  logic en, in_acc, fin_pend_q;
  logic out_v_q;
  logic sw_busy, sw_done, sw_rd_en, sw_wr_en;
  logic [AW-1:0] sw_rd_addr, sw_wr_addr;
  logic [31:0]   sw_wr_data;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en && !fin_pend_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // stage A: accepted beat
  logic        a_v_q;
  logic [1:0]  a_op_q;
  logic [7:0]  a_idx_q;
  logic [31:0] a_val_q;

  // stage B: input product
  logic               b_v_q;
  logic [1:0]         b_op_q;
  logic [7:0]         b_idx_q;
  logic [31:0]        b_val_q;
  logic signed [63:0] b_p_q;

  logic signed [47:0] b_x, b_diff;
  logic signed [31:0] b_fl;
  logic [AW-1:0]      b_seg, b_ref;
  logic               slope_we, fin_start;

  always_comb begin
    b_x  = 48'(b_p_q >>> 16) + 48'(K * 65536);
    b_fl = b_x[47:16];
    if (b_fl[31]) begin
      b_seg = '0;
    end else if (b_fl > 32'(SEGMENTS - 1)) begin
      b_seg = LAST_IDX;
    end else begin
      b_seg = b_fl[AW-1:0];
    end
    b_ref  = (b_seg == '0) ? AW'(1) : b_seg;
    b_diff = b_x - (48'(b_ref) <<< 16);
  end

  assign slope_we  = en && b_v_q && (b_op_q == lpla_pkg::OP_LOAD) &&
                     ({1'b0, b_idx_q} < 9'(SEGMENTS));
  assign fin_start = en && b_v_q && (b_op_q == lpla_pkg::OP_FIN);

  // stage C: segment chosen, table data arriving
  logic               c_v_q;
  logic signed [31:0] c_dh_q;
  logic [15:0]        c_dl_q;
  logic [AW-1:0]      c_seg_q;
  logic [31:0]        slope_rd, slope_sw_rd, off_rd;

  lpla_ram #(.W(32), .D(SEGMENTS)) u_slope_ram (
    .clk_i  (clk_i),
    .we_i   (slope_we),
    .wa_i   (b_idx_q[AW-1:0]),
    .wd_i   (b_val_q),
    .re_a_i (en),
    .ra_a_i (b_seg),
    .rd_a_o (slope_rd),
    .re_b_i (sw_rd_en),
    .ra_b_i (sw_rd_addr),
    .rd_b_o (slope_sw_rd)
  );

  lpla_ram #(.W(32), .D(SEGMENTS)) u_offset_ram (
    .clk_i  (clk_i),
    .we_i   (sw_wr_en),
    .wa_i   (sw_wr_addr),
    .wd_i   (sw_wr_data),
    .re_a_i (en),
    .ra_a_i (b_seg),
    .rd_a_o (off_rd),
    .re_b_i (1'b0),
    .ra_b_i (b_seg),
    .rd_b_o ()
  );

  lpla_sweep #(.SEGMENTS(SEGMENTS)) u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fin_start),
    .slope_rd_i (slope_sw_rd),
    .busy_o     (sw_busy),
    .done_o     (sw_done),
    .rd_en_o    (sw_rd_en),
    .rd_addr_o  (sw_rd_addr),
    .wr_en_o    (sw_wr_en),
    .wr_addr_o  (sw_wr_addr),
    .wr_data_o  (sw_wr_data)
  );

  // stage D: segment products
  logic               d_v_q;
  logic signed [63:0] d_m1_q;
  logic signed [48:0] d_m2_q;
  logic [31:0]        d_off_q;
  logic [AW-1:0]      d_seg_q;

  // stage E: function value
  logic               e_v_q;
  logic signed [65:0] e_y_q;
  logic [AW-1:0]      e_seg_q;

  // stage F: output scaling products
  logic          f_v_q, f_neg_q;
  logic [64:0]   f_hi_q;
  logic [62:0]   f_lo_q;
  logic [AW-1:0] f_seg_q;
  logic [65:0]   e_mag;

  assign e_mag = e_y_q[65] ? 66'(-e_y_q) : 66'(e_y_q);

  // final rounding and clipping
  logic [63:0] g_prod;
  logic [48:0] g_q;
  logic [31:0] g_res;
  logic        g_sat;

  always_comb begin
    g_prod = {f_hi_q[15:0], 32'd0} + 64'(f_lo_q);
    g_q    = f_neg_q ? 49'((65'(g_prod) + 65'h0FFFF) >> 16) : 49'(g_prod >> 16);
    g_sat  = 1'b0;
    g_res  = f_neg_q ? 32'(-g_q) : g_q[31:0];
    if (|f_hi_q[64:16]) begin
      g_sat = 1'b1;
      g_res = f_neg_q ? 32'h80000000 : 32'h7FFFFFFF;
    end else if (!f_neg_q && (g_q > 49'h7FFFFFFF)) begin
      g_sat = 1'b1;
      g_res = 32'h7FFFFFFF;
    end else if (f_neg_q && (g_q > 49'h80000000)) begin
      g_sat = 1'b1;
      g_res = 32'h80000000;
    end
  end

  logic [31:0]   out_act_q;
  logic [AW-1:0] out_seg_q;
  logic          out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      c_v_q      <= 1'b0;
      d_v_q      <= 1'b0;
      e_v_q      <= 1'b0;
      f_v_q      <= 1'b0;
      out_v_q    <= 1'b0;
      fin_pend_q <= 1'b0;
    end else begin
      if (in_acc && (s_axis_tuser == lpla_pkg::OP_FIN)) begin
        fin_pend_q <= 1'b1;
      end else if (sw_done) begin
        fin_pend_q <= 1'b0;
      end
      if (en) begin
        a_v_q   <= in_acc;
        b_v_q   <= a_v_q;
        c_v_q   <= b_v_q && (b_op_q == lpla_pkg::OP_EVAL);
        d_v_q   <= c_v_q;
        e_v_q   <= d_v_q;
        f_v_q   <= e_v_q;
        out_v_q <= f_v_q;
      end
    end
  end

  // payload: advance on enable, hold on stall
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q    <= s_axis_tuser;
      a_idx_q   <= s_axis_tdata[7:0];
      a_val_q   <= s_axis_tdata[39:8];
      b_op_q    <= a_op_q;
      b_idx_q   <= a_idx_q;
      b_val_q   <= a_val_q;
      b_p_q     <= $signed(a_val_q) * $signed({1'b0, inv_q});
      c_dh_q    <= b_diff[47:16];
      c_dl_q    <= b_diff[15:0];
      c_seg_q   <= b_seg;
      d_m1_q    <= c_dh_q * $signed(slope_rd);
      d_m2_q    <= 49'($signed({1'b0, c_dl_q}) * $signed(slope_rd));
      d_off_q   <= off_rd;
      d_seg_q   <= c_seg_q;
      e_y_q     <= 66'(d_m1_q) + 66'(d_m2_q >>> 16) + 66'($signed(d_off_q));
      e_seg_q   <= d_seg_q;
      f_neg_q   <= e_y_q[65];
      f_hi_q    <= 65'(e_mag[65:32] * scale_q);
      f_lo_q    <= 63'(e_mag[31:0] * scale_q);
      f_seg_q   <= e_seg_q;
      out_act_q <= g_res;
      out_seg_q <= f_seg_q;
      out_sat_q <= g_sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {8'(out_seg_q), out_act_q};
  assign m_axis_tuser  = out_sat_q;

  `LPLA_ASSERT_IMP(a_no_accept_in_sweep, clk_i, rst_ni, sw_busy, !s_axis_tready,
    "beat accepted during offset sweep")
  `LPLA_ASSERT_IMP(a_no_load_in_sweep, clk_i, rst_ni, sw_busy, !slope_we,
    "slope write collides with offset sweep")
  `LPLA_ASSERT_NXT(a_sweep_follows_fin, clk_i, rst_ni, fin_start, sw_busy,
    "finalize did not start the sweep")

endmodule

### test/tb.sv
// Self-checking stream testbench for the learned piecewise-linear activation block
module tb;

  localparam int NSEG = lpla_pkg::SEGMENTS_DEF;
  localparam int HALF = NSEG / 2;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [31:0] val;
  } op_beat_t;

  typedef struct packed {
    logic [31:0] act;
    logic [7:0]  seg;
    logic        sat;
  } act_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  learned_piecewise_linear_activation_top u_top (.*);

  always #4 clk_i = ~clk_i;

  op_beat_t  pending_ops[$];
  act_beat_t expected_acts[$];
  logic signed [31:0] slopes[NSEG];
  logic signed [31:0] offsets[NSEG];
  logic [30:0] out_scale = lpla_pkg::SCALE_RST;
  logic [30:0] in_scale = lpla_pkg::SCALE_RST;
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_sat = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_tx = 1'b0;
  bit in_taken = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [71:0] v);
    if (v > 72'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -72'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [71:0] floor16(logic signed [71:0] v);
    return v >>> 16;
  endfunction

  task automatic rebuild_offsets();
    logic signed [71:0] acc;
    acc = 0;
    for (int j = HALF; j < NSEG; j++) begin
      offsets[j] = clip32(acc);
      acc = acc + slopes[j];
    end
    acc = 0;
    for (int j = HALF - 1; j >= 1; j--) begin
      acc = acc - slopes[j];
      offsets[j] = clip32(acc);
    end
    offsets[0] = offsets[1];
  endtask

  // apply one accepted op beat to the shadow tables, or queue the expected result of an evaluate
  task automatic predict_activation(op_beat_t b);
    logic signed [71:0] x, fl, seg, rf, diff, dh, dl, y;
    logic signed [127:0] prod, q;
    act_beat_t e;
    if (b.op == lpla_pkg::OP_LOAD) begin
      if (b.idx < NSEG) slopes[b.idx] = b.val;
    end else if (b.op == lpla_pkg::OP_FIN) begin
      rebuild_offsets();
    end else if (b.op == lpla_pkg::OP_EVAL) begin
      x = floor16(72'($signed(b.val)) * 72'($signed({1'b0, in_scale}))) + HALF * 65536;
      fl = floor16(x);
      seg = fl < 0 ? 0 : (fl > NSEG - 1 ? NSEG - 1 : fl);
      rf = seg < 1 ? 1 : seg;
      diff = x - rf * 65536;
      dh = floor16(diff);
      dl = diff - dh * 65536;
      y = dh * slopes[seg] + floor16(dl * slopes[seg]) + offsets[seg];
      prod = y * $signed({1'b0, out_scale});
      q = prod >>> 16;
      e.sat = 1'b0;
      if (q > 128'sh7FFFFFFF) begin
        e.sat = 1'b1;
        e.act = 32'h7FFFFFFF;
      end else if (q < -128'sh80000000) begin
        e.sat = 1'b1;
        e.act = 32'h80000000;
      end else begin
        e.act = q[31:0];
      end
      e.seg = seg[7:0];
      expected_acts.push_back(e);
    end
  endtask

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        predict_activation(pending_ops.pop_front());
        n_sent++;
        send_gap = pick_gap();
      end
      if (s_axis_tvalid && !in_taken) begin
        // hold the beat
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0 && !hold_tx) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_ops[0].op;
        s_axis_tdata <= {pending_ops[0].val, pending_ops[0].idx};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_recv++;
      if (m_axis_tuser) n_sat++;
      if (expected_acts.size() == 0) begin
        report("unexpected beat", m_axis_tdata, '0);
      end else begin
        act_beat_t e;
        e = expected_acts.pop_front();
        if (m_axis_tdata[31:0] !== e.act) report("activation", m_axis_tdata[31:0], e.act);
        if (m_axis_tdata[39:32] !== e.seg) report("segment", m_axis_tdata[39:32], e.seg);
        if (m_axis_tuser !== e.sat) report("saturated", m_axis_tuser, e.sat);
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) out_scale = data[30:0]; else in_scale = data[30:0];
  endtask

  task automatic wait_idle();
    while (pending_ops.size() > 0 || expected_acts.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_op(logic [1:0] op, logic [7:0] idx, logic [31:0] val);
    op_beat_t b;
    b.op = op; b.idx = idx; b.val = val;
    pending_ops.push_back(b);
  endtask

  function automatic logic [31:0] rand_slope();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 12'hFFF : 12'h000, 20'($urandom())};
      default: return $signed($urandom_range(0, 32'h140000)) - 32'sh0A0000;
    endcase
  endfunction

  // a full table load, a finalize, then a burst of mostly samples mixed with loads, NOPs and finalizes
  task automatic queue_set(int nevals);
    for (int s = 0; s < NSEG; s++) push_op(lpla_pkg::OP_LOAD, s, rand_slope());
    push_op(lpla_pkg::OP_FIN, $urandom(), $urandom());
    for (int k = 0; k < nevals; k++) begin
      case ($urandom_range(0, 19))
        0: push_op(lpla_pkg::OP_LOAD, $urandom_range(NSEG, 255), $urandom());
        1: push_op(lpla_pkg::OP_NOP, $urandom(), $urandom());
        2: push_op(lpla_pkg::OP_LOAD, $urandom_range(0, NSEG - 1), rand_slope());
        3: push_op(lpla_pkg::OP_FIN, $urandom(), $urandom());
        default: push_op(lpla_pkg::OP_EVAL, $urandom(), rand_sample());
      endcase
    end
  endtask

  logic [31:0] scale_set[6] = '{32'h10000, 32'h1, 32'h7FFFFFFF, 32'h0, 32'h4000, 32'h28000};

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extreme slopes and samples, index out of range, unused op
    for (int s = 0; s < NSEG; s++)
      push_op(lpla_pkg::OP_LOAD, s, s[0] ? 32'h7FFFFFFF : 32'h80000000);
    push_op(lpla_pkg::OP_LOAD, 8'hFF, 32'h12345678);
    push_op(lpla_pkg::OP_FIN, 8'h00, 32'h0);
    push_op(lpla_pkg::OP_NOP, 8'hAA, 32'hFFFFFFFF);
    push_op(lpla_pkg::OP_EVAL, 8'hFF, 32'h7FFFFFFF);
    push_op(lpla_pkg::OP_EVAL, 8'h00, 32'h80000000);
    push_op(lpla_pkg::OP_EVAL, 8'h00, 32'h0);
    push_op(lpla_pkg::OP_EVAL, 8'h00, 32'hFFFFFFFF);
    push_op(lpla_pkg::OP_EVAL, 8'h00, 32'h00078000);
    wait_idle();
    for (int p = 0; p < 12; p++) begin
      apb_write(3'd0, scale_set[p % 6]);
      apb_write(3'd4, p == 11 ? 32'h0 : scale_set[(p * 5 + 2) % 6]);
      queue_set(p < 10 ? 150 : 60);
      if (p == 4) begin
        // pause the sender until the pipeline drains
        while (pending_ops.size() > 120) @(posedge clk_i);
        hold_tx = 1'b1;
        while (expected_acts.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        hold_tx = 1'b0;
      end
      wait_idle();
    end
    $display("sent %0d op beats, checked %0d results (%0d saturated)", n_sent, n_recv, n_sat);
    $display("covered 12 scale settings including zero, one and maximum");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
